/* sv/cwa_pkg.sv */
// Shared types, codes and helper functions of the chain wire allocator.
package cwa_pkg;

    localparam int ROW_W   = 64;
    localparam int CHAIN_W = 6;
    localparam int CL_IN_W = 2;
    localparam int CNT_W   = 7;
    localparam int CFG_W   = 7;
    localparam int REG_W   = 2;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_LOOKUP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_REFUSED     = 2'd1,
        ST_BAD_RELEASE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        POL_ONE_TO_ONE   = 2'd0,
        POL_STATIC       = 2'd1,
        POL_STATIC_STALL = 2'd2,
        POL_DYNAMIC      = 2'd3
    } t_policy;

    typedef enum logic [REG_W-1:0] {
        REG_POLICY        = 2'd0,
        REG_CHAIN_COUNT   = 2'd1,
        REG_CLUSTER_COUNT = 2'd2,
        REG_WIRES         = 2'd3
    } t_reg_idx;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic init_step;
        logic update;
        logic result;
    } t_dp_ctrl;

    // datapath to controller
    typedef struct packed {
        logic init_last;
    } t_dp_stat;

    // bits at 0, stride, 2*stride, ... built with a wrapping phase counter
    function automatic logic [ROW_W-1:0] stride_mask(input int unsigned stride);
        logic [ROW_W-1:0] mask;
        int unsigned      ph;
        mask = '0;
        ph   = 0;
        for (int c = 0; c < ROW_W; c++) begin
            if (ph == 0) begin
                mask[c] = 1'b1;
            end
            ph = (ph + 1 == stride) ? 0 : ph + 1;
        end
        return mask;
    endfunction

    function automatic logic [ROW_W-1:0] low_mask(input logic [CNT_W-1:0] n);
        logic [ROW_W-1:0] mask;
        if (n >= CNT_W'(ROW_W)) begin
            mask = '1;
        end else begin
            mask = (ROW_W'(1) << n) - ROW_W'(1);
        end
        return mask;
    endfunction

endpackage

/* sv/cwa_ifs.sv */
// Handshake channels of the chain wire allocator: request, result and register write.
interface cwa_in_if
    import cwa_pkg::*;
();
    logic                 valid;
    logic                 ready;
    t_cmd                 cmd;
    logic [CL_IN_W-1:0]   cluster;
    logic [CHAIN_W-1:0]   chain;

    modport source (output valid, cmd, cluster, chain, input ready);
    modport sink   (input valid, cmd, cluster, chain, output ready);
endinterface

interface cwa_out_if
    import cwa_pkg::*;
();
    logic                 valid;
    logic                 ready;
    t_status              status;
    logic                 found;
    logic [CHAIN_W-1:0]   first_free;
    logic [CNT_W-1:0]     free_count;
    logic                 chain_mapped;

    modport source (output valid, status, found, first_free, free_count, chain_mapped,
                    input ready);
    modport sink   (input valid, status, found, first_free, free_count, chain_mapped,
                    output ready);
endinterface

interface cwa_cfg_if
    import cwa_pkg::*;
();
    logic                 valid;
    logic                 ready;
    t_reg_idx             index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/chain_wire_allocator_unit.sv */
// Chain wire allocator top level: sequencer, datapath and channel hookup.
// Each request passes the row update (read-modify-write of the cluster row) and the
// first-free encode state, after an init sweep of every cluster row for init; the
// encode waits for a free result register. One request is in progress at a time.
// Reset (synchronous, active low): registers take their reset values, row 0 is fully
// mapped and free, other rows clear, all in-use counts zero; no clearing pass.
module chain_wire_allocator_unit
    import cwa_pkg::*;
#(
    parameter int MAX_CHAINS   = 64,
    parameter int MAX_CLUSTERS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cwa_in_if.sink     i_in,
    cwa_out_if.source  o_out,
    cwa_cfg_if.sink    i_cfg
);

    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;

    // register writes are taken in any cycle
    assign i_cfg.ready = 1'b1;

    cwa_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_cmd_is_init (i_in.cmd == CMD_INIT),
        .i_out_ready   (o_out.ready),
        .i_stat        (w_stat),
        .o_in_ready    (i_in.ready),
        .o_out_valid   (o_out.valid),
        .o_ctrl        (w_ctrl)
    );

    cwa_datapath #(
        .MAX_CHAINS   (MAX_CHAINS),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_cmd          (i_in.cmd),
        .i_cluster      (i_in.cluster),
        .i_chain        (i_in.chain),
        .o_status       (o_out.status),
        .o_found        (o_out.found),
        .o_first_free   (o_out.first_free),
        .o_free_count   (o_out.free_count),
        .o_chain_mapped (o_out.chain_mapped)
    );

endmodule

/* sv/cwa_ctrl.sv */
// Sequencer of the chain wire allocator: init sweep, row update, result encode.
module cwa_ctrl
    import cwa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_cmd_is_init,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_dp_ctrl o_ctrl
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INIT = 4'b0010,
        S_UPD  = 4'b0100,
        S_FIND = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = i_cmd_is_init ? S_INIT : S_UPD;
                end
            end
            S_INIT: begin
                o_ctrl.init_step = 1'b1;
                if (i_stat.init_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_ctrl.update = 1'b1;
                n_state       = S_FIND;
            end
            S_FIND: begin
                // hold until the result register is free or being drained
                if (!r_out_valid || i_out_ready) begin
                    o_ctrl.result = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_ctrl.result) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* sv/cwa_datapath.sv */
// Register file, cluster rows and result encoder of the chain wire allocator.
module cwa_datapath
    import cwa_pkg::*;
#(
    parameter int MAX_CHAINS   = 64,
    parameter int MAX_CLUSTERS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_ctrl           i_ctrl,
    output t_dp_stat           o_stat,
    input  logic               i_cfg_we,
    input  t_reg_idx           i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  t_cmd               i_cmd,
    input  logic [CL_IN_W-1:0] i_cluster,
    input  logic [CHAIN_W-1:0] i_chain,
    output t_status            o_status,
    output logic               o_found,
    output logic [CHAIN_W-1:0] o_first_free,
    output logic [CNT_W-1:0]   o_free_count,
    output logic               o_chain_mapped
);

    localparam int CL_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam logic [4:0]       MAX_CL_V = 5'(MAX_CLUSTERS);
    localparam logic [CNT_W-1:0] MAX_CH_V = CNT_W'(MAX_CHAINS);

    // configuration
    t_policy          r_policy;
    logic [CNT_W-1:0] r_chain_count;
    logic [2:0]       r_cluster_count;
    logic [CNT_W-1:0] r_wires;

    // table
    logic [MAX_CHAINS-1:0] r_mapped [MAX_CLUSTERS];
    logic [MAX_CHAINS-1:0] r_free   [MAX_CLUSTERS];
    logic [CNT_W-1:0]      r_cnt    [MAX_CLUSTERS];

    // request and sweep
    t_cmd               r_cmd;
    logic [CL_IN_W-1:0] r_cl;
    logic [CHAIN_W-1:0] r_chain;
    logic [CL_W-1:0]    r_init_idx;
    t_status            r_status, n_status;

    // result
    t_status            r_o_status;
    logic               r_o_found;
    logic [CHAIN_W-1:0] r_o_first;
    logic [CNT_W-1:0]   r_o_fc;
    logic               r_o_mapped;

    logic [CNT_W-1:0] w_n;
    logic [4:0]       w_k;
    logic [4:0]       w_k_m1;
    logic [CNT_W-1:0] w_wires;
    logic [ROW_W-1:0] w_nmask;
    logic [ROW_W-1:0] w_stride [MAX_CLUSTERS];
    logic [ROW_W-1:0] w_init_row;
    logic [CL_W-1:0]  w_ri;
    logic             w_cl_ok;
    logic             w_chain_ok;
    logic [ROW_W-1:0] w_m64, w_f64, w_bit;
    logic [CNT_W-1:0] w_cnt;
    logic             w_m, w_f;
    logic [ROW_W-1:0] n_m64, n_f64;
    logic [CNT_W-1:0] n_cnt;
    logic [ROW_W-1:0] w_hit;
    logic [CNT_W-1:0] w_fc;
    logic [CHAIN_W-1:0] w_first;

    // effective counts
    assign w_n     = (r_chain_count > MAX_CH_V) ? MAX_CH_V : r_chain_count;
    assign w_k     = (r_cluster_count == 3'd0) ? 5'd1 :
                     ((5'(r_cluster_count) > MAX_CL_V) ? MAX_CL_V : 5'(r_cluster_count));
    assign w_k_m1  = w_k - 5'd1;
    assign w_wires = (r_policy == POL_ONE_TO_ONE) ? w_n : r_wires;
    assign w_nmask = low_mask(w_n);

    for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_stride
        assign w_stride[g] = stride_mask(g + 1);
    end

    // row built for the cluster under the sweep
    always_comb begin
        w_init_row = '0;
        if (5'(r_init_idx) < w_k) begin
            case (r_policy)
                POL_ONE_TO_ONE: w_init_row = w_nmask;
                POL_DYNAMIC:    w_init_row = '0;
                default:        w_init_row = (w_stride[w_k_m1[CL_W-1:0]] << r_init_idx)
                                             & w_nmask;
            endcase
        end
    end

    assign o_stat.init_last = (r_init_idx == CL_W'(MAX_CLUSTERS - 1));

    // addressed row
    assign w_ri       = CL_W'(r_cl);
    assign w_cl_ok    = 5'(r_cl) < w_k;
    assign w_chain_ok = CNT_W'(r_chain) < w_n;
    assign w_m64      = ROW_W'(r_mapped[w_ri]);
    assign w_f64      = ROW_W'(r_free[w_ri]);
    assign w_cnt      = r_cnt[w_ri];
    assign w_bit      = ROW_W'(1) << r_chain;
    assign w_m        = w_m64[r_chain];
    assign w_f        = w_f64[r_chain];

    // read-modify-write of one row
    always_comb begin
        logic dec;
        logic alloc_ok;
        dec      = 1'b0;
        n_m64    = w_m64;
        n_f64    = w_f64;
        n_cnt    = w_cnt;
        n_status = ST_OK;
        alloc_ok = w_chain_ok && ((r_policy == POL_DYNAMIC) ? ((w_cnt < w_wires) && !w_m)
                                                             : (w_m && w_f));
        if (w_cl_ok) begin
            case (r_cmd)
                CMD_ALLOC: begin
                    if (!alloc_ok) begin
                        n_status = ST_REFUSED;
                    end else begin
                        if (r_policy == POL_DYNAMIC) begin
                            n_m64 = w_m64 | w_bit;
                        end else begin
                            n_f64 = w_f64 & ~w_bit;
                        end
                        if (w_cnt != '1) begin
                            n_cnt = w_cnt + CNT_W'(1);
                        end
                    end
                end
                CMD_RELEASE: begin
                    if (w_chain_ok) begin
                        case (r_policy)
                            POL_ONE_TO_ONE: begin
                                if (!w_f) begin
                                    n_f64 = w_f64 | w_bit;
                                    dec   = 1'b1;
                                end
                            end
                            POL_DYNAMIC: begin
                                if (w_m) begin
                                    n_m64 = w_m64 & ~w_bit;
                                    dec   = 1'b1;
                                end
                            end
                            default: begin
                                if (w_m) begin
                                    if (w_f) begin
                                        n_status = ST_BAD_RELEASE;
                                    end else begin
                                        n_f64 = w_f64 | w_bit;
                                        dec   = 1'b1;
                                    end
                                end
                            end
                        endcase
                        if (dec && (w_cnt != '0)) begin
                            n_cnt = w_cnt - CNT_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // encode from the rewritten row
    assign w_hit = w_nmask & ((r_policy == POL_DYNAMIC) ? ~w_m64 : (w_m64 & w_f64));
    assign w_fc  = (w_cnt >= w_wires) ? '0 : (w_wires - w_cnt);

    always_comb begin
        w_first = '0;
        for (int w = ROW_W - 1; w >= 0; w--) begin
            if (w_hit[w]) begin
                w_first = CHAIN_W'(w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy        <= POL_ONE_TO_ONE;
            r_chain_count   <= CNT_W'(64);
            r_cluster_count <= 3'd1;
            r_wires         <= CNT_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POLICY:        r_policy        <= t_policy'(i_cfg_data[1:0]);
                REG_CHAIN_COUNT:   r_chain_count   <= i_cfg_data;
                REG_CLUSTER_COUNT: r_cluster_count <= i_cfg_data[2:0];
                REG_WIRES:         r_wires         <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // reset leaves the table as an init under the reset configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
                r_mapped[i] <= (i == 0) ? '1 : '0;
                r_free[i]   <= (i == 0) ? '1 : '0;
                r_cnt[i]    <= '0;
            end
        end else if (i_ctrl.init_step) begin
            r_mapped[r_init_idx] <= w_init_row[MAX_CHAINS-1:0];
            r_free[r_init_idx]   <= w_init_row[MAX_CHAINS-1:0];
            r_cnt[r_init_idx]    <= '0;
        end else if (i_ctrl.update && w_cl_ok) begin
            r_mapped[w_ri] <= n_m64[MAX_CHAINS-1:0];
            r_free[w_ri]   <= n_f64[MAX_CHAINS-1:0];
            r_cnt[w_ri]    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_idx <= '0;
        end else if (i_ctrl.load) begin
            r_init_idx <= '0;
        end else if (i_ctrl.init_step) begin
            r_init_idx <= r_init_idx + CL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= i_cmd;
            r_cl    <= i_cluster;
            r_chain <= i_chain;
        end
        if (i_ctrl.update) begin
            r_status <= n_status;
        end
        if (i_ctrl.result) begin
            r_o_status <= r_status;
            if (w_cl_ok) begin
                r_o_found  <= (w_fc != '0) && (w_hit != '0);
                r_o_first  <= ((w_fc != '0) && (w_hit != '0)) ? w_first : '0;
                r_o_fc     <= w_fc;
                r_o_mapped <= w_chain_ok && w_m;
            end else begin
                r_o_found  <= 1'b0;
                r_o_first  <= '0;
                r_o_fc     <= '0;
                r_o_mapped <= 1'b0;
            end
        end
    end

    assign o_status       = r_o_status;
    assign o_found        = r_o_found;
    assign o_first_free   = r_o_first;
    assign o_free_count   = r_o_fc;
    assign o_chain_mapped = r_o_mapped;

endmodule

/* sv/cwa_chk.sv */
// Port-level assertions for the chain wire allocator, bound to the top level.
module cwa_chk
    import cwa_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input t_status            i_status,
    input logic               i_found,
    input logic [CHAIN_W-1:0] i_first_free,
    input logic [CNT_W-1:0]   i_free_count
);

    logic [1:0] r_pending;
    logic       w_in_xfer, w_out_xfer;

    assign w_in_xfer  = i_in_valid && i_in_ready;
    assign w_out_xfer = i_out_valid && i_out_ready;

    // requests taken minus results handed out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'(w_in_xfer) - 2'(w_out_xfer);
        end
    end

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != 2'd0))
        else $error("result shown without a pending request");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !i_in_ready)
        else $error("request taken while another is in progress");

    a_first_free_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |-> (i_first_free == '0))
        else $error("first_free nonzero with nothing found");

    a_found_needs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_free_count == '0)) |-> (!i_found &&
            (i_status == ST_OK || i_status == ST_REFUSED || i_status == ST_BAD_RELEASE)))
        else $error("found with zero free wires or bad status code");

endmodule

bind chain_wire_allocator_unit cwa_chk u_cwa_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_found      (o_out.found),
    .i_first_free (o_out.first_free),
    .i_free_count (o_out.free_count)
);
